/* rtl/nmeack_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package nmeack_pkg;

  localparam logic [7:0] START_MARK = 8'h24;  // '$'
  localparam logic [7:0] CHECK_MARK = 8'h2A;  // '*'
  localparam int unsigned HEX_BASE_BITS = 4;  // base 16 digit width

  typedef logic [1:0] status_t;
  localparam status_t ST_PLAIN = 2'd0;
  localparam status_t ST_GOOD  = 2'd1;
  localparam status_t ST_BAD   = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM,
    S_CMP,
    S_EMIT_RD,
    S_EMIT_LD
  } state_t;

  // {digit ok, digit value}
  function automatic logic [HEX_BASE_BITS:0] hex_digit(input logic [7:0] ch);
    logic [HEX_BASE_BITS:0] res;
    res = '0;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      res = {1'b1, 4'(ch - 8'h30)};
    end else if (ch >= 8'h41 && ch <= 8'h46) begin
      res = {1'b1, 4'(ch - 8'h37)};
    end else if (ch >= 8'h61 && ch <= 8'h66) begin
      res = {1'b1, 4'(ch - 8'h57)};
    end
    return res;
  endfunction

  // checksum carried by the two trailing digits
  function automatic logic [7:0] rx_sum(input logic [7:0] hi, input logic [7:0] lo);
    logic [HEX_BASE_BITS:0] h;
    logic [HEX_BASE_BITS:0] l;
    logic [7:0] res;
    h = hex_digit(hi);
    l = hex_digit(lo);
    if (!h[HEX_BASE_BITS]) begin
      res = 8'h00;
    end else if (!l[HEX_BASE_BITS]) begin
      res = {4'h0, h[HEX_BASE_BITS-1:0]};
    end else begin
      res = {h[HEX_BASE_BITS-1:0], l[HEX_BASE_BITS-1:0]};
    end
    return res;
  endfunction

endpackage

`default_nettype wire

/* rtl/nmeack_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface nmeack_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface nmeack_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] sentence_byte;
  logic       last;

  modport source (output valid, output status, output sentence_byte, output last,
                  input ready);
  modport sink   (input valid, input status, input sentence_byte, input last,
                  output ready);
endinterface

`default_nettype wire

/* rtl/nmeack_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module nmeack_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/nmea_sentence_checksum_framer_core.sv */
// nmea sentence framer with checksum check
// in_item carries one received character (rx_byte) per item; out_item carries
// results (status, sentence_byte, last), valid/ready on both sides.
// a plain character (no sentence end) is taken and its single result is
// shown in the output register on the next cycle.
// a character that closes a sentence of n bytes starts the sequencer: the
// xor of the n-4 payload bytes is gathered one byte a cycle through the
// store's single read port, the S_CMP state compares, then a bad sentence
// gives one error result, a good one gives n results, each read, then
// loaded into the output register, the last one flagged
// in_item.ready is low while the sequencer runs or the output register is
// full and not being taken; a stalled receiver simply holds the sequencer
// synchronous active-low reset empties the output register and sets the
// write position to zero; the byte store needs no clearing, only bytes
// written since the last restart are ever read
`timescale 1ns / 1ps
`default_nettype none

module nmea_sentence_checksum_framer_core #(
  parameter int BUFFER_BYTES = 64
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  nmeack_in_if.sink      in_item,
  nmeack_out_if.source   out_item
);

  localparam int AW = $clog2(BUFFER_BYTES);

  nmeack_pkg::state_t state_r, state_nxt;

  logic [AW-1:0] wp_r, wp_nxt;       // next write position
  logic [AW-1:0] n_r, n_nxt;         // bytes in the closed sentence
  logic [AW-1:0] ra_r, ra_nxt;       // read address counter
  logic          pend_r, pend_nxt;   // read data arrives this cycle
  logic [7:0]    sum_r, sum_nxt;     // payload xor accumulator
  logic          start_r, start_nxt; // byte at position 0 is '$'
  logic [7:0]    prev1_r, prev1_nxt;
  logic [7:0]    prev2_r, prev2_nxt;
  logic [7:0]    hi_r, hi_nxt;
  logic [7:0]    lo_r, lo_nxt;

  // output register
  logic                 ov_r, ov_nxt;
  nmeack_pkg::status_t  ostat_r, ostat_nxt;
  logic [7:0]           obyte_r, obyte_nxt;
  logic                 olast_r, olast_nxt;

  // store port
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  logic          out_free;
  logic [AW-1:0] pos;
  logic          issue;

  nmeack_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_item.rx_byte),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_free      = !ov_r || out_item.ready;
  assign in_item.ready = (state_r == nmeack_pkg::S_IDLE) && out_free;

  assign out_item.valid         = ov_r;
  assign out_item.status        = ostat_r;
  assign out_item.sentence_byte = obyte_r;
  assign out_item.last          = olast_r;

  // restart on '$' or when the store holds BUFFER_BYTES-1 bytes
  assign pos = (in_item.rx_byte == nmeack_pkg::START_MARK ||
                wp_r >= AW'(BUFFER_BYTES - 1)) ? '0 : wp_r;

  // more payload bytes to read while ra + 3 < n
  assign issue = ({1'b0, ra_r} + (AW+1)'(3)) < {1'b0, n_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= nmeack_pkg::S_IDLE;
      wp_r    <= '0;
      pend_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wp_r    <= wp_nxt;
      pend_r  <= pend_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r     <= n_nxt;
    ra_r    <= ra_nxt;
    sum_r   <= sum_nxt;
    start_r <= start_nxt;
    prev1_r <= prev1_nxt;
    prev2_r <= prev2_nxt;
    hi_r    <= hi_nxt;
    lo_r    <= lo_nxt;
    ostat_r <= ostat_nxt;
    obyte_r <= obyte_nxt;
    olast_r <= olast_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    wp_nxt    = wp_r;
    n_nxt     = n_r;
    ra_nxt    = ra_r;
    pend_nxt  = 1'b0;
    sum_nxt   = sum_r;
    start_nxt = start_r;
    prev1_nxt = prev1_r;
    prev2_nxt = prev2_r;
    hi_nxt    = hi_r;
    lo_nxt    = lo_r;
    ostat_nxt = ostat_r;
    obyte_nxt = obyte_r;
    olast_nxt = olast_r;
    ov_nxt    = ov_r && !out_item.ready;

    ram_we    = 1'b0;
    ram_waddr = pos;
    ram_re    = 1'b0;
    ram_raddr = ra_r;

    case (state_r)
      nmeack_pkg::S_IDLE: begin
        if (in_item.valid && in_item.ready) begin
          ram_we    = 1'b1;
          prev1_nxt = in_item.rx_byte;
          prev2_nxt = prev1_r;
          if (pos == '0) begin
            start_nxt = (in_item.rx_byte == nmeack_pkg::START_MARK);
          end
          // sentence end: '$' first and '*' two places back
          if (pos >= AW'(2) && start_r && prev2_r == nmeack_pkg::CHECK_MARK) begin
            wp_nxt    = '0;
            n_nxt     = pos + AW'(1);
            hi_nxt    = prev1_r;
            lo_nxt    = in_item.rx_byte;
            ra_nxt    = AW'(1);
            sum_nxt   = '0;
            state_nxt = nmeack_pkg::S_SUM;
          end else begin
            wp_nxt    = pos + AW'(1);
            ov_nxt    = 1'b1;
            ostat_nxt = nmeack_pkg::ST_PLAIN;
            obyte_nxt = '0;
            olast_nxt = 1'b1;
          end
        end
      end

      nmeack_pkg::S_SUM: begin
        // read ahead one byte while folding in the previous one
        if (issue) begin
          ram_re   = 1'b1;
          ra_nxt   = ra_r + AW'(1);
          pend_nxt = 1'b1;
        end
        if (pend_r) begin
          sum_nxt = sum_r ^ ram_rdata;
        end
        if (!issue && !pend_r) begin
          state_nxt = nmeack_pkg::S_CMP;
        end
      end

      nmeack_pkg::S_CMP: begin
        if (out_free) begin
          if (sum_r == nmeack_pkg::rx_sum(hi_r, lo_r)) begin
            ra_nxt    = '0;
            state_nxt = nmeack_pkg::S_EMIT_RD;
          end else begin
            ov_nxt    = 1'b1;
            ostat_nxt = nmeack_pkg::ST_BAD;
            obyte_nxt = '0;
            olast_nxt = 1'b1;
            state_nxt = nmeack_pkg::S_IDLE;
          end
        end
      end

      nmeack_pkg::S_EMIT_RD: begin
        ram_re    = 1'b1;
        state_nxt = nmeack_pkg::S_EMIT_LD;
      end

      nmeack_pkg::S_EMIT_LD: begin
        // read data holds until the next read, so a stall just waits here
        if (out_free) begin
          ov_nxt    = 1'b1;
          ostat_nxt = nmeack_pkg::ST_GOOD;
          obyte_nxt = ram_rdata;
          olast_nxt = (ra_r == n_r - AW'(1));
          if (ra_r == n_r - AW'(1)) begin
            state_nxt = nmeack_pkg::S_IDLE;
          end else begin
            ra_nxt    = ra_r + AW'(1);
            state_nxt = nmeack_pkg::S_EMIT_RD;
          end
        end
      end

      default: begin
        state_nxt = nmeack_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/nmeack_chk.sv */
`timescale 1ns / 1ps
`default_nettype none

module nmeack_chk (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] out_status,
  input wire logic [7:0] out_sentence_byte,
  input wire logic       out_last
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_sentence_byte) && $stable(out_last))
    else $error("result changed while stalled");

  // no new item taken unless the output register can make room
  a_in_room: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid || out_ready)
    else $error("input ready with output register blocked");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == nmeack_pkg::ST_PLAIN ||
      out_status == nmeack_pkg::ST_GOOD || out_status == nmeack_pkg::ST_BAD)
    else $error("unknown status code");

  // plain and error results are single, byte-free
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != nmeack_pkg::ST_GOOD |->
      out_last && out_sentence_byte == 8'h00)
    else $error("plain or error result malformed");

endmodule

bind nmea_sentence_checksum_framer_core nmeack_chk u_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_ready          (in_item.ready),
  .out_valid         (out_item.valid),
  .out_ready         (out_item.ready),
  .out_status        (out_item.status),
  .out_sentence_byte (out_item.sentence_byte),
  .out_last          (out_item.last)
);

`default_nettype wire

/* verif/nmeack_sentence_checker.sv */
`timescale 1ns / 1ps

module nmeack_sentence_checker #(
  parameter int BUFFER_BYTES = 64
) (
  input  logic  clk,
  input  logic  rst_n,
  nmeack_in_if  in_mon,
  nmeack_out_if out_mon,
  output int    fail_count,
  output int    pending,
  output int    results_seen,
  output int    good_sentences,
  output int    bad_sentences
);

  typedef struct packed {
    nmeack_pkg::status_t status;
    logic [7:0]          sentence_byte;
    logic                last;
  } framer_result_t;

  // own copy of the byte store and write position
  logic [7:0]     held_bytes [BUFFER_BYTES];
  int unsigned    fill_level = 0;
  framer_result_t expected_results [$];

  int fails     = 0;
  int results_n = 0;
  int good_n    = 0;
  int bad_n     = 0;

  function automatic int digit_of(input logic [7:0] ch);
    if (ch >= "0" && ch <= "9") return int'(ch) - int'("0");
    if (ch >= "A" && ch <= "F") return int'(ch) - int'("A") + 10;
    if (ch >= "a" && ch <= "f") return int'(ch) - int'("a") + 10;
    return -1;
  endfunction

  function automatic logic [7:0] carried_sum(input logic [7:0] hi, input logic [7:0] lo);
    int h;
    int l;
    h = digit_of(hi);
    l = digit_of(lo);
    if (h < 0) return 8'h00;
    if (l < 0) return 8'(h);
    return 8'(h * 16 + l);
  endfunction

  task automatic frame_byte(input logic [7:0] ch);
    int unsigned    n;
    logic [7:0]     payload_xor;
    framer_result_t r;
    if (ch == nmeack_pkg::START_MARK || fill_level >= BUFFER_BYTES - 1) fill_level = 0;
    held_bytes[fill_level] = ch;
    fill_level = fill_level + 1;
    n = fill_level;
    if (n >= 3 && held_bytes[0] == nmeack_pkg::START_MARK &&
        held_bytes[n-3] == nmeack_pkg::CHECK_MARK) begin
      payload_xor = 8'h00;
      for (int unsigned i = 1; i + 3 < n; i++) payload_xor ^= held_bytes[i];
      fill_level = 0;
      if (payload_xor == carried_sum(held_bytes[n-2], held_bytes[n-1])) begin
        for (int unsigned i = 0; i < n; i++) begin
          r.status        = nmeack_pkg::ST_GOOD;
          r.sentence_byte = held_bytes[i];
          r.last          = (i + 1 == n);
          expected_results.push_back(r);
        end
        good_n++;
      end else begin
        r = '{status: nmeack_pkg::ST_BAD, sentence_byte: 8'h00, last: 1'b1};
        expected_results.push_back(r);
        bad_n++;
      end
    end else begin
      r = '{status: nmeack_pkg::ST_PLAIN, sentence_byte: 8'h00, last: 1'b1};
      expected_results.push_back(r);
    end
  endtask

  always @(posedge clk) begin : watch
    framer_result_t got;
    framer_result_t want;
    if (rst_n) begin
      // results first: they always belong to items taken at earlier edges
      if (out_mon.valid && out_mon.ready) begin
        got.status        = out_mon.status;
        got.sentence_byte = out_mon.sentence_byte;
        got.last          = out_mon.last;
        results_n++;
        if (expected_results.size() == 0) begin
          if (fails < 10)
            $display("%0t: unexpected result status %0d byte %02h last %0d",
                     $realtime, got.status, got.sentence_byte, got.last);
          fails++;
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status || got.sentence_byte !== want.sentence_byte ||
              got.last !== want.last) begin
            if (fails < 10)
              $display("%0t: mismatch, expected status %0d byte %02h last %0d, got %0d %02h %0d",
                       $realtime, want.status, want.sentence_byte, want.last,
                       got.status, got.sentence_byte, got.last);
            fails++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) frame_byte(in_mon.rx_byte);
    end
    pending        <= expected_results.size();
    fail_count     <= fails;
    results_seen   <= results_n;
    good_sentences <= good_n;
    bad_sentences  <= bad_n;
  end

endmodule

/* verif/nmea_sentence_checksum_framer_core_tb.sv */
`timescale 1ns / 1ps

module nmea_sentence_checksum_framer_core_tb;

  localparam int BUFFER_BYTES = 64;

  // how the two trailing digits of a generated sentence are formed
  typedef enum int {
    CK_UPPER,
    CK_LOWER,
    CK_WRONG,
    CK_FIRST_NOT_HEX,
    CK_SECOND_NOT_HEX
  } checksum_form_t;

  logic clk = 1'b0;
  logic rst_n;

  nmeack_in_if  in_bus ();
  nmeack_out_if out_bus ();

  int fail_count;
  int pending;
  int results_seen;
  int good_sentences;
  int bad_sentences;

  int   items_sent = 0;
  logic burst_mode = 1'b0;  // no gaps between bytes while set
  logic long_hold_done = 1'b0;

  always #10 clk = ~clk;

  nmea_sentence_checksum_framer_core #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_item (in_bus),
    .out_item(out_bus)
  );

  nmeack_sentence_checker #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) sentence_monitor (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_bus),
    .out_mon       (out_bus),
    .fail_count    (fail_count),
    .pending       (pending),
    .results_seen  (results_seen),
    .good_sentences(good_sentences),
    .bad_sentences (bad_sentences)
  );

  // overall time limit, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("timeout with %0d results still expected", pending);
    $display("** nmea_sentence_checksum_framer_core: FAILED **");
    $finish;
  end

  function automatic logic is_hex(input logic [7:0] ch);
    return (ch >= "0" && ch <= "9") || (ch >= "A" && ch <= "F") || (ch >= "a" && ch <= "f");
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic lower);
    if (nib < 10) return 8'h30 + 8'(nib);
    return (lower ? 8'h61 : 8'h41) + 8'(nib) - 8'd10;
  endfunction

  // any byte that is no hex digit and does not restart the sentence
  function automatic logic [7:0] non_hex_char();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (is_hex(b) || b == nmeack_pkg::START_MARK);
    return b;
  endfunction

  // payload byte that neither restarts nor closes the sentence
  function automatic logic [7:0] payload_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == nmeack_pkg::START_MARK || b == nmeack_pkg::CHECK_MARK);
    return b;
  endfunction

  // offer one item, keeping valid high between back-to-back items
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid   <= 1'b1;
    in_bus.rx_byte <= b;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // '$', random payload, '*', then two digits formed as asked
  task automatic send_sentence(input int payload_len, input checksum_form_t form);
    logic [7:0] payload_xor;
    logic [7:0] b;
    logic [7:0] hi;
    logic [7:0] lo;
    logic       lower;
    payload_xor = 8'h00;
    send_byte(nmeack_pkg::START_MARK);
    for (int i = 0; i < payload_len; i++) begin
      b = payload_byte();
      payload_xor ^= b;
      send_byte(b);
    end
    send_byte(nmeack_pkg::CHECK_MARK);
    lower = 1'b0;
    case (form)
      CK_LOWER: begin
        lower = 1'b1;
      end
      CK_WRONG: begin
        payload_xor ^= 8'($urandom_range(1, 255));
      end
      default: begin
      end
    endcase
    hi = hex_char(payload_xor[7:4], lower);
    lo = hex_char(payload_xor[3:0], lower);
    if (form == CK_FIRST_NOT_HEX) hi = non_hex_char();
    if (form == CK_SECOND_NOT_HEX) lo = non_hex_char();
    send_byte(hi);
    send_byte(lo);
  endtask

  // receiver: random stalls, quiet stretches, and one long hold-off
  initial begin : receiver
    int stall;
    int taken;
    logic quiet;
    taken = 0;
    quiet = 1'b0;
    out_bus.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (taken % 32 == 0) quiet = ($urandom_range(0, 3) == 0);
      if (!long_hold_done && results_seen >= 150) begin
        // block fills and has to stall the sender meanwhile
        stall = 400;
        long_hold_done = 1'b1;
      end else begin
        stall = quiet ? 0 : $urandom_range(0, 19);
      end
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      @(posedge clk);
      while (!out_bus.valid) @(posedge clk);
      taken++;
    end
  end

  initial begin : stimulus
    int r;
    int n;
    checksum_form_t form;
    rst_n          <= 1'b0;
    in_bus.valid   <= 1'b0;
    in_bus.rx_byte <= 8'h00;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extreme bytes ahead of any '$', then the checksum corner cases
    send_byte(8'h00);
    send_byte(8'hFF);
    send_text("$*00");      // shortest sentence, empty xor
    send_text("$*5A");      // shortest sentence, wrong sum
    send_text("$A*41");     // upper-case digits
    send_text("$j*6a");     // lower-case digits
    send_text("$*Zz");      // first digit not hex, reads as zero
    send_byte(nmeack_pkg::START_MARK);  // second digit not hex, first digit alone
    send_byte(8'h05);
    send_text("*5G");

    // one sentence of the greatest length the store holds
    send_sentence(BUFFER_BYTES - 5, CK_UPPER);
    // a run that never closes, so the store wraps round
    for (int i = 0; i < BUFFER_BYTES + 6; i++) send_byte(payload_byte());

    while (items_sent < 350) begin
      burst_mode = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 70) begin
        n = $urandom_range(0, 12);
        case ($urandom_range(0, 9))
          0, 1, 2: form = CK_UPPER;
          3, 4:    form = CK_LOWER;
          5, 6:    form = CK_WRONG;
          7:       form = CK_FIRST_NOT_HEX;
          default: form = CK_SECOND_NOT_HEX;
        endcase
        send_sentence(n, form);
      end else if (r < 85) begin
        // noise over the full byte range
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) send_byte(8'($urandom_range(0, 255)));
      end else if (r < 93) begin
        // broken sentence: cut off before or inside the checksum
        send_byte(nmeack_pkg::START_MARK);
        n = $urandom_range(0, 8);
        for (int i = 0; i < n; i++) send_byte(payload_byte());
        if ($urandom_range(0, 1)) begin
          send_byte(nmeack_pkg::CHECK_MARK);
          send_byte(hex_char(4'($urandom_range(0, 15)), 1'b0));
        end
      end else begin
        send_sentence($urandom_range(40, BUFFER_BYTES - 5),
                      $urandom_range(0, 1) ? CK_UPPER : CK_WRONG);
      end
    end
    in_bus.valid <= 1'b0;

    // drain: every expectation met, then a wait for stray results
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("run covered %0d bytes in and %0d results out", items_sent, results_seen);
    $display("%0d good sentences, %0d bad checksums, full-length sentence and store wrap included",
             good_sentences, bad_sentences);
    if (fail_count == 0 && pending == 0) begin
      $display("** nmea_sentence_checksum_framer_core: PASSED **");
    end else begin
      $display("%0d failures", fail_count);
      $display("** nmea_sentence_checksum_framer_core: FAILED **");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/nmeack_pkg.sv
rtl/nmeack_if.sv
rtl/nmeack_ram.sv
rtl/nmea_sentence_checksum_framer_core.sv
rtl/nmeack_chk.sv
verif/nmeack_sentence_checker.sv
verif/nmea_sentence_checksum_framer_core_tb.sv
